/* src/bspr_pkg.sv */
// bspr_pkg: shared types and constants of the block-sum press/release detector
// used by every file of the block; depends on nothing
package bspr_pkg;

   localparam int LANES       = 2;
   localparam int LANE_BITS   = 1;
   localparam int SAMPLE_BITS = 12;
   localparam int THRESH_BITS = 14;
   localparam int CHAN_BITS   = 4;
   localparam int NOTE_BITS   = 7;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 14;

   // register indexes of the csr write channel
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESS_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_CHANNEL      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTE_LANE_ZERO    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOTE_LANE_ONE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VELOCITY_LANE_ZERO = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VELOCITY_LANE_ONE  = 3'd6;

   // register reset values
   localparam logic [THRESH_BITS-1:0] RESET_THRESHOLD    = 14'd1600;
   localparam logic [CHAN_BITS-1:0]   RESET_BASE_CHANNEL = 4'd2;
   localparam logic [NOTE_BITS-1:0]   RESET_NOTE_ZERO    = 7'd80;
   localparam logic [NOTE_BITS-1:0]   RESET_NOTE_ONE     = 7'd100;
   localparam logic [NOTE_BITS-1:0]   RESET_VELOCITY     = 7'd100;

   // what one lane found at the end of a block
   typedef struct packed {
      logic fire;
      logic is_on;
   } lane_event_type;

   // register values the merge stage needs to build a response
   typedef struct packed {
      logic [CHAN_BITS-1:0]             base_channel;
      logic [LANES-1:0][NOTE_BITS-1:0]  note;
      logic [LANES-1:0][NOTE_BITS-1:0]  velocity;
   } event_cfg_type;

endpackage

/* src/bspr_ifs.sv */
// bspr channel interfaces: request, response and csr write channels
// depends on bspr_pkg
interface bspr_req_if;
   logic                             valid;
   logic                             ready;
   logic [bspr_pkg::SAMPLE_BITS-1:0] sample_lane_zero;
   logic [bspr_pkg::SAMPLE_BITS-1:0] sample_lane_one;

   modport source (output valid, output sample_lane_zero, output sample_lane_one,
                   input ready);
   modport sink   (input valid, input sample_lane_zero, input sample_lane_one,
                   output ready);
endinterface

interface bspr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           is_note_on;
   logic [bspr_pkg::CHAN_BITS-1:0] midi_channel;
   logic [bspr_pkg::NOTE_BITS-1:0] note_number;
   logic [bspr_pkg::NOTE_BITS-1:0] note_velocity;
   logic                           last_event;

   modport source (output valid, output is_note_on, output midi_channel,
                   output note_number, output note_velocity, output last_event,
                   input ready);
   modport sink   (input valid, input is_note_on, input midi_channel,
                   input note_number, input note_velocity, input last_event,
                   output ready);
endinterface

interface bspr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bspr_pkg::CSR_INDEX_BITS-1:0] index;
   logic [bspr_pkg::CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* src/bspr_lane.sv */
// bspr_lane: per-lane block accumulator and press/release state machine
// depends on bspr_pkg
module bspr_lane #(
   parameter int SUM_BITS = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [bspr_pkg::SAMPLE_BITS-1:0] sample,
   input  logic                             take,
   input  logic                             block_end,
   input  logic [bspr_pkg::THRESH_BITS-1:0] press_thr,
   input  logic [bspr_pkg::THRESH_BITS-1:0] release_thr,
   output bspr_pkg::lane_event_type         lane_evt
);

   localparam int CMP_BITS = (SUM_BITS > bspr_pkg::THRESH_BITS) ? SUM_BITS
                                                                : bspr_pkg::THRESH_BITS;

   typedef enum logic [1:0] {
      ST_UNINIT   = 2'd0,
      ST_RELEASED = 2'd1,
      ST_PRESSED  = 2'd2
   } lane_state_type;

   lane_state_type      state_ff, state_in;
   logic [SUM_BITS-1:0] running_ff;
   logic [SUM_BITS-1:0] previous_ff;
   logic [SUM_BITS-1:0] cur;
   logic [CMP_BITS-1:0] cur_x, prev_x;
   logic                pressed_now, released_now;

   assign cur    = running_ff + SUM_BITS'(sample);
   assign cur_x  = CMP_BITS'(cur);
   assign prev_x = CMP_BITS'(previous_ff);

   // strict compares: a change equal to the threshold is no event
   assign pressed_now  = (cur_x < prev_x) && ((prev_x - cur_x) > CMP_BITS'(press_thr));
   assign released_now = (cur_x > prev_x) && ((cur_x - prev_x) > CMP_BITS'(release_thr));

   always_comb begin
      state_in       = state_ff;
      lane_evt.fire  = 1'b0;
      lane_evt.is_on = 1'b0;
      unique case (state_ff)
         ST_UNINIT: begin
            state_in = ST_RELEASED;
         end
         ST_RELEASED: begin
            if (pressed_now) begin
               state_in       = ST_PRESSED;
               lane_evt.fire  = take && block_end;
               lane_evt.is_on = 1'b1;
            end
         end
         ST_PRESSED: begin
            if (released_now) begin
               state_in      = ST_RELEASED;
               lane_evt.fire = take && block_end;
            end
         end
         default: begin
            state_in = ST_RELEASED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_UNINIT;
         running_ff  <= '0;
         previous_ff <= '0;
      end else if (take) begin
         if (block_end) begin
            state_ff    <= state_in;
            running_ff  <= '0;
            previous_ff <= cur;
         end else begin
            running_ff <= cur;
         end
      end
   end

endmodule

/* src/bspr_merge.sv */
// bspr_merge: collects lane events of one scan and emits them in lane order
// depends on bspr_pkg and bspr_rsp_if
module bspr_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  bspr_pkg::lane_event_type [bspr_pkg::LANES-1:0] lane_evt,
   input  bspr_pkg::event_cfg_type                       cfg,
   output logic                                          can_load,
   bspr_rsp_if.source                                    rsp
);

   logic [bspr_pkg::LANES-1:0]     pend_ff, pend_in;
   logic [bspr_pkg::LANES-1:0]     pend_on_ff;
   logic [bspr_pkg::LANES-1:0]     sel_mask;
   logic [bspr_pkg::LANE_BITS-1:0] sel;
   logic                           pend_any, pend_multi, move;
   logic                           out_valid_ff;
   logic                           on_ff, last_ff;
   logic [bspr_pkg::CHAN_BITS-1:0] chan_ff;
   logic [bspr_pkg::NOTE_BITS-1:0] note_ff, vel_ff;

   assign move       = !out_valid_ff || rsp.ready;
   assign pend_any   = |pend_ff;
   assign pend_multi = $countones(pend_ff) > 1;
   assign can_load   = !pend_any || (!pend_multi && move);

   // lowest pending lane goes first
   always_comb begin
      sel = '0;
      for (int l = bspr_pkg::LANES - 1; l >= 0; l--) begin
         if (pend_ff[l]) sel = bspr_pkg::LANE_BITS'(l);
      end
      sel_mask = bspr_pkg::LANES'(1) << sel;
   end

   always_comb begin
      pend_in = pend_ff;
      if (move) pend_in = pend_in & ~sel_mask;
      if (load) begin
         for (int l = 0; l < bspr_pkg::LANES; l++) begin
            pend_in[l] = pend_in[l] | lane_evt[l].fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (move) out_valid_ff <= pend_any;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int l = 0; l < bspr_pkg::LANES; l++) begin
            if (lane_evt[l].fire) pend_on_ff[l] <= lane_evt[l].is_on;
         end
      end
      if (move && pend_any) begin
         on_ff   <= pend_on_ff[sel];
         chan_ff <= cfg.base_channel + bspr_pkg::CHAN_BITS'(sel);
         note_ff <= cfg.note[sel];
         vel_ff  <= pend_on_ff[sel] ? cfg.velocity[sel] : '0;
         last_ff <= (pend_ff & ~sel_mask) == '0;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.is_note_on    = on_ff;
   assign rsp.midi_channel  = chan_ff;
   assign rsp.note_number   = note_ff;
   assign rsp.note_velocity = vel_ff;
   assign rsp.last_event    = last_ff;

endmodule

/* src/block_sum_press_release_detector_unit.sv */
// block_sum_press_release_detector_unit: top level of the detector
// depends on bspr_pkg, bspr_ifs, bspr_lane and bspr_merge
//
// Each request carries one scan, one sample per sensor lane. Both lanes run
// side by side: each adds its sample to a running block sum, and on the last
// scan of a block compares the block sum with the previous one. A released
// lane whose sum falls by more than press_threshold sends a note-on with its
// velocity; a pressed lane whose sum rises by more than release_threshold
// sends a note-off with velocity zero. The first block of a lane only stores
// its sum. Responses come out lane zero first, last_event marks the final one
// of a scan, and a scan that ends no block or fires nothing gives none.
// Rate: one request per cycle. Requests that end no block are always taken;
// the merge stage drains lane events one per cycle through the response
// register, so req ready drops only on a block-end request while the merge
// stage still holds two events, or one event behind a stalled response.
// A block-end request's lane events pass through the merge stage's pending
// register, then the response register. Csr writes are always ready
// and take effect the next cycle; write them only while idle.
module block_sum_press_release_detector_unit #(
   parameter int SCANS_PER_BLOCK = 4
) (
   input  logic       clock,
   input  logic       reset,
   bspr_req_if.sink   req_ch,
   bspr_rsp_if.source rsp_ch,
   bspr_csr_if.sink   csr_ch
);

   // block sums never overflow: width grows with the block length
   localparam int SUM_BITS = bspr_pkg::SAMPLE_BITS + $clog2(SCANS_PER_BLOCK);
   localparam int CNT_BITS = (SCANS_PER_BLOCK > 1) ? $clog2(SCANS_PER_BLOCK) : 1;

   // configuration registers
   logic [bspr_pkg::THRESH_BITS-1:0]                press_ff, release_ff;
   logic [bspr_pkg::CHAN_BITS-1:0]                  base_ff;
   logic [bspr_pkg::LANES-1:0][bspr_pkg::NOTE_BITS-1:0] note_ff, vel_ff;

   // scan counter within a block
   logic [CNT_BITS-1:0] scan_count_ff;

   logic                                           take, block_end, can_load;
   logic [bspr_pkg::LANES-1:0][bspr_pkg::SAMPLE_BITS-1:0] samples;
   bspr_pkg::lane_event_type [bspr_pkg::LANES-1:0] lane_evt;
   bspr_pkg::event_cfg_type                        evt_cfg;

   assign csr_ch.ready = 1'b1;

   // csr decoder, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff   <= bspr_pkg::RESET_THRESHOLD;
         release_ff <= bspr_pkg::RESET_THRESHOLD;
         base_ff    <= bspr_pkg::RESET_BASE_CHANNEL;
         note_ff[0] <= bspr_pkg::RESET_NOTE_ZERO;
         note_ff[1] <= bspr_pkg::RESET_NOTE_ONE;
         vel_ff[0]  <= bspr_pkg::RESET_VELOCITY;
         vel_ff[1]  <= bspr_pkg::RESET_VELOCITY;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bspr_pkg::CSR_PRESS_THRESHOLD:    press_ff   <= csr_ch.wdata;
            bspr_pkg::CSR_RELEASE_THRESHOLD:  release_ff <= csr_ch.wdata;
            bspr_pkg::CSR_BASE_CHANNEL:       base_ff    <= csr_ch.wdata[bspr_pkg::CHAN_BITS-1:0];
            bspr_pkg::CSR_NOTE_LANE_ZERO:     note_ff[0] <= csr_ch.wdata[bspr_pkg::NOTE_BITS-1:0];
            bspr_pkg::CSR_NOTE_LANE_ONE:      note_ff[1] <= csr_ch.wdata[bspr_pkg::NOTE_BITS-1:0];
            bspr_pkg::CSR_VELOCITY_LANE_ZERO: vel_ff[0]  <= csr_ch.wdata[bspr_pkg::NOTE_BITS-1:0];
            bspr_pkg::CSR_VELOCITY_LANE_ONE:  vel_ff[1]  <= csr_ch.wdata[bspr_pkg::NOTE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // request handshake: only a block-end request waits on the merge stage
   assign req_ch.ready = can_load || !block_end;
   assign take         = req_ch.valid && req_ch.ready;
   assign block_end    = scan_count_ff == CNT_BITS'(SCANS_PER_BLOCK - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_count_ff <= '0;
      end else if (take) begin
         scan_count_ff <= block_end ? '0 : scan_count_ff + CNT_BITS'(1);
      end
   end

   assign samples[0] = req_ch.sample_lane_zero;
   assign samples[1] = req_ch.sample_lane_one;

   // one accumulator and state machine per lane
   for (genvar l = 0; l < bspr_pkg::LANES; l++) begin : g_lane
      bspr_lane #(
         .SUM_BITS (SUM_BITS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .sample      (samples[l]),
         .take        (take),
         .block_end   (block_end),
         .press_thr   (press_ff),
         .release_thr (release_ff),
         .lane_evt    (lane_evt[l])
      );
   end

   assign evt_cfg.base_channel = base_ff;
   assign evt_cfg.note         = note_ff;
   assign evt_cfg.velocity     = vel_ff;

   // merge lane events into the response stream
   bspr_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (take && block_end),
      .lane_evt (lane_evt),
      .cfg      (evt_cfg),
      .can_load (can_load),
      .rsp      (rsp_ch)
   );

endmodule

/* src/bspr_checker.sv */
// bspr_checker: port-level assertions for the detector top level
// depends on bspr_pkg; bound to block_sum_press_release_detector_unit
module bspr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_is_note_on,
   input logic [bspr_pkg::NOTE_BITS-1:0] rsp_note_velocity,
   input logic                           rsp_last_event
);

   // response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // note-off always carries velocity zero
   a_off_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_note_on |-> rsp_note_velocity == '0)
      else $error("note-off with nonzero velocity");

   // second event of a scan follows straight after the first
   a_second_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_event |=> rsp_valid)
      else $error("missing final event of scan");

   // reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind block_sum_press_release_detector_unit bspr_checker u_bspr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_is_note_on    (rsp_ch.is_note_on),
   .rsp_note_velocity (rsp_ch.note_velocity),
   .rsp_last_event    (rsp_ch.last_event)
);
